// File: rtl/cosine_distance_engine_defines.svh
// ----------------------------------------------------------------------------
// Cosine distance engine assertion macros
// Shared property forms for the checker. Each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef COSINE_DISTANCE_ENGINE_DEFINES_SVH
`define COSINE_DISTANCE_ENGINE_DEFINES_SVH

// same-cycle implication
`define CDE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cosine distance engine: same-cycle check failed");

// next-cycle implication
`define CDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cosine distance engine: next-cycle check failed");

`endif

// File: rtl/cde_pkg.sv
// ----------------------------------------------------------------------------
// Cosine distance engine package
// Widths, constants, queue entry type and back-end states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cde_pkg;

    localparam int ELEM_W      = 16;
    localparam int PROD_E_W    = 2 * ELEM_W;
    localparam int SQ_W        = 2 * ELEM_W - 1;
    localparam int DOT_W       = 41;
    localparam int NORM_W      = 40;
    localparam int HALF_W      = NORM_W / 2;
    localparam int PROD_W      = 2 * NORM_W;
    localparam int ROOT_W      = NORM_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int FRAC_W      = 14;
    localparam int NUM_W       = DOT_W + FRAC_W;
    localparam int DIST_W      = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MUL_STEPS   = 4;
    localparam int SQRT_STEPS  = PROD_W / 2;
    localparam int DIV_STEPS   = NUM_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [DOT_W-1:0]  DOT_MAX  = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic [DOT_W-1:0]  DOT_MIN  = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
    localparam logic [DIST_W-1:0] ONE_Q14  = DIST_W'(1 << FRAC_W);
    localparam logic [DIST_W-1:0] TWO_Q14  = DIST_W'(2 << FRAC_W);

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [NORM_W-1:0] norm_a;
        logic [NORM_W-1:0] norm_b;
    } cde_sums_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } cde_state_t;

endpackage

`default_nettype wire

// File: rtl/cosine_distance_engine.sv
// ----------------------------------------------------------------------------
// Cosine distance engine
// Streams element pairs of two vectors and returns 1 - cos(a, b) in Q2.14.
// ----------------------------------------------------------------------------
//  channel | direction | word contents
//  s_*     | in        | tdata: elem_a[15:0], elem_b[31:16]; tlast: last pair
//  m_*     | out       | tdata: distance[15:0]; tuser: zero_norm
//
//  Element pairs enter at one per cycle unless a last pair waits for the
//  queue; the front end registers each product before adding it to the sums.
//  Each vector holds the back end through load, norm product, square-root
//  digits, quotient bits, saturate, output; a zero norm skips to output. A
//  two-entry queue holds finished sums, so short vectors stall the input while
//  the back end works. Reset clears the accumulators and all handshake state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cosine_distance_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // elem_a[15:0], elem_b[31:16]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // distance[15:0]
    output logic             m_tuser    // zero_norm[0]
);
    import cde_pkg::*;

    logic      push_valid, push_ready, q_valid, q_pop;
    cde_sums_t push_data, q_data;

    cde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .elem_a     (s_tdata[ELEM_W-1:0]),
        .elem_b     (s_tdata[2*ELEM_W-1:ELEM_W]),
        .last       (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    cde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    cde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .distance  (m_tdata),
        .zero_norm (m_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/cde_front.sv
// ----------------------------------------------------------------------------
// Cosine distance front end
// Multiplies each element pair, accumulates dot and norms with saturation,
// and pushes the finished sums into the queue on the last word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cde_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [cde_pkg::ELEM_W-1:0] elem_a,
    input  wire logic signed [cde_pkg::ELEM_W-1:0] elem_b,
    input  wire logic                          last,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output cde_pkg::cde_sums_t                 push_data
);
    import cde_pkg::*;

    logic                       p_valid_reg, p_valid_next;
    logic                       p_last_reg;
    logic signed [PROD_E_W-1:0] ab_reg;
    logic [SQ_W-1:0]            aa_reg, bb_reg;
    logic signed [PROD_E_W-1:0] ab_full, aa_full, bb_full;

    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [NORM_W-1:0] na_reg, na_next;
    logic [NORM_W-1:0] nb_reg, nb_next;
    logic [DOT_W:0]    dot_wide;
    logic [NORM_W:0]   na_wide, nb_wide;
    logic [DOT_W-1:0]  dot_sat;
    logic [NORM_W-1:0] na_sat, nb_sat;
    logic              acc_take, acc_fire, load;

    assign acc_take   = !p_last_reg || push_ready;
    assign acc_fire   = p_valid_reg && acc_take;
    assign in_ready   = !p_valid_reg || acc_take;
    assign load       = in_valid && in_ready;
    assign push_valid = p_valid_reg && p_last_reg;

    always_comb
    begin
        ab_full = elem_a * elem_b;
        aa_full = elem_a * elem_a;
        bb_full = elem_b * elem_b;
    end

    always_comb
    begin
        dot_wide = {dot_reg[DOT_W-1], dot_reg}
                 + {{(DOT_W+1-PROD_E_W){ab_reg[PROD_E_W-1]}}, ab_reg};
        na_wide  = {1'b0, na_reg} + {{(NORM_W+1-SQ_W){1'b0}}, aa_reg};
        nb_wide  = {1'b0, nb_reg} + {{(NORM_W+1-SQ_W){1'b0}}, bb_reg};

        if (dot_wide[DOT_W] != dot_wide[DOT_W-1])
        begin
            dot_sat = dot_wide[DOT_W] ? DOT_MIN : DOT_MAX;
        end
        else
        begin
            dot_sat = dot_wide[DOT_W-1:0];
        end
        na_sat = na_wide[NORM_W] ? NORM_MAX : na_wide[NORM_W-1:0];
        nb_sat = nb_wide[NORM_W] ? NORM_MAX : nb_wide[NORM_W-1:0];

        push_data.dot    = dot_sat;
        push_data.norm_a = na_sat;
        push_data.norm_b = nb_sat;
    end

    always_comb
    begin
        p_valid_next = p_valid_reg;
        dot_next     = dot_reg;
        na_next      = na_reg;
        nb_next      = nb_reg;
        if (load)
        begin
            p_valid_next = 1'b1;
        end
        else if (acc_fire)
        begin
            p_valid_next = 1'b0;
        end
        if (acc_fire)
        begin
            // clear after the last word, keep growing otherwise
            dot_next = p_last_reg ? '0 : dot_sat;
            na_next  = p_last_reg ? '0 : na_sat;
            nb_next  = p_last_reg ? '0 : nb_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            dot_reg     <= '0;
            na_reg      <= '0;
            nb_reg      <= '0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            dot_reg     <= dot_next;
            na_reg      <= na_next;
            nb_reg      <= nb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_last_reg <= last;
            ab_reg     <= ab_full;
            aa_reg     <= aa_full[SQ_W-1:0];
            bb_reg     <= bb_full[SQ_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/cde_queue.sv
// ----------------------------------------------------------------------------
// Cosine distance sum queue
// Short first-in first-out store of finished sums between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cde_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_valid,
    output logic                    wr_ready,
    input  wire cde_pkg::cde_sums_t wr_data,
    output logic                    rd_valid,
    input  wire logic               rd_pop,
    output cde_pkg::cde_sums_t      rd_data
);
    import cde_pkg::*;

    cde_sums_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              wr_fire, rd_fire;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_fire ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = rd_fire ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire && !rd_fire)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (rd_fire && !wr_fire)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cde_back.sv
// ----------------------------------------------------------------------------
// Cosine distance back end
// Forms the norm product in four partial products, takes its square root one
// digit a cycle, divides the scaled dot product one bit a cycle, saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cde_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire cde_pkg::cde_sums_t            q_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cde_pkg::DIST_W-1:0]         distance,
    output logic                               zero_norm
);
    import cde_pkg::*;

    cde_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sign_reg, sign_next;
    logic [NORM_W-1:0] na_reg, na_next, nb_reg, nb_next;
    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [2*HALF_W-1:0] pp_reg, pp_next;
    logic [1:0]        pp_sh_reg, pp_sh_next;
    logic [PROD_W-1:0] prod_reg, prod_next, pp_shifted;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DIST_W-1:0] res_reg, res_next;
    logic              zn_reg, zn_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] dist_reg;
    logic              zn_out_reg;

    logic              norm_zero, last_mul, last_sqrt, last_div, out_free, out_load;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [REM_W+1:0]  sq_rem_sh, sq_trial;
    logic [ROOT_W:0]   dv_rem_sh;
    logic [DOT_W-1:0]  dot_mag;
    logic              q_big;

    assign norm_zero = (q_data.norm_a == '0) || (q_data.norm_b == '0);
    assign last_mul  = (cnt_reg == CNT_W'(MUL_STEPS));
    assign last_sqrt = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
    assign last_div  = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = norm_zero ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:  if (last_mul)  state_next = ST_SQRT;
            ST_SQRT: if (last_sqrt) state_next = ST_DIV;
            ST_DIV:  if (last_div)  state_next = ST_FIN;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: if (out_free)  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_pop    = q_valid;
            ST_DONE: out_load = out_free;
            ST_MUL, ST_SQRT, ST_DIV, ST_FIN: ;
            default: ;
        endcase
    end

    always_comb
    begin
        mul_a = cnt_reg[0] ? na_reg[NORM_W-1:HALF_W] : na_reg[HALF_W-1:0];
        mul_b = cnt_reg[1] ? nb_reg[NORM_W-1:HALF_W] : nb_reg[HALF_W-1:0];
        case (pp_sh_reg)
            2'd0:    pp_shifted = {{(PROD_W-2*HALF_W){1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_shifted = {pp_reg, {(2*HALF_W){1'b0}}};
        endcase
        sq_rem_sh = {rem_reg, prod_reg[PROD_W-1 -: 2]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        dv_rem_sh = {rem_reg[ROOT_W-1:0], num_reg[NUM_W-1]};
        dot_mag   = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : dot_reg;
        q_big     = |num_reg[NUM_W-1:FRAC_W];
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        sign_next      = sign_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        dot_next       = dot_reg;
        pp_next        = pp_reg;
        pp_sh_next     = pp_sh_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        num_next       = num_reg;
        res_next       = res_reg;
        zn_next        = zn_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                na_next   = q_data.norm_a;
                nb_next   = q_data.norm_b;
                dot_next  = q_data.dot;
                cnt_next  = '0;
                prod_next = '0;
                zn_next   = norm_zero;
                res_next  = ONE_Q14;
            end
            ST_MUL:
            begin
                pp_next    = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
                pp_sh_next = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
                if (cnt_reg != '0)
                begin
                    prod_next = prod_reg + pp_shifted;
                end
                cnt_next = last_mul ? '0 : CNT_W'(cnt_reg + 1'b1);
                rem_next  = '0;
                root_next = '0;
            end
            ST_SQRT:
            begin
                prod_next = {prod_reg[PROD_W-3:0], 2'b00};
                if (sq_rem_sh >= sq_trial)
                begin
                    rem_next  = REM_W'(sq_rem_sh - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_rem_sh[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = last_sqrt ? '0 : CNT_W'(cnt_reg + 1'b1);
                if (last_sqrt)
                begin
                    rem_next  = '0;
                    num_next  = {dot_mag, {FRAC_W{1'b0}}};
                    sign_next = dot_reg[DOT_W-1];
                end
            end
            ST_DIV:
            begin
                // root stays; rem_reg low bits carry the partial remainder
                if (dv_rem_sh >= {1'b0, root_reg})
                begin
                    rem_next = REM_W'(dv_rem_sh - {1'b0, root_reg});
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = REM_W'(dv_rem_sh);
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
            ST_FIN:
            begin
                if (sign_reg)
                begin
                    res_next = q_big ? TWO_Q14
                                     : ONE_Q14 + {{(DIST_W-FRAC_W){1'b0}}, num_reg[FRAC_W-1:0]};
                end
                else
                begin
                    res_next = q_big ? '0
                                     : ONE_Q14 - {{(DIST_W-FRAC_W){1'b0}}, num_reg[FRAC_W-1:0]};
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg  <= sign_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        dot_reg   <= dot_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        num_reg   <= num_next;
        res_reg   <= res_next;
        zn_reg    <= zn_next;
        if (out_load)
        begin
            dist_reg   <= res_reg;
            zn_out_reg <= zn_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign zero_norm = zn_out_reg;

endmodule

`default_nettype wire

// File: rtl/cde_checker.sv
// ----------------------------------------------------------------------------
// Cosine distance engine checker
// Watches the result channel of the top level through its ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cosine_distance_engine_defines.svh"

module cde_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);
    import cde_pkg::*;

    `CDE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `CDE_ASSERT_NOW(a_zero_norm_one, m_tvalid && m_tuser, m_tdata == ONE_Q14)
    `CDE_ASSERT_NOW(a_dist_range, m_tvalid, m_tdata <= TWO_Q14)

endmodule

bind cosine_distance_engine cde_checker u_cde_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
